// ===== hw/rtl/rrsas_pkg.sv =====
// Package for the round-robin sprite animation scheduler.
// Holds the sizing constants, register index codes and the structs passed
// between the lanes, the merge stage and the top level. No dependencies.
package rrsas_pkg;

  // Number of sequence lanes
  localparam int MAX_SEQUENCES = 5;

  // Fixed field widths
  localparam int MASK_W        = 5;
  localparam int SETUP_REGS    = 5;
  localparam int SETUP_W       = 16;
  localparam int FRAME_W       = 8;
  localparam int SPEED_W       = 8;
  localparam int COUNT_FIELD_W = 3;
  localparam int SEQ_OUT_W     = 3;
  localparam int CFG_IDX_W     = 3;

  // Derived widths: lane index, and a count that can hold MAX_SEQUENCES
  localparam int SEQ_W = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1;
  localparam int CNT_W = $clog2(MAX_SEQUENCES + 1);

  // Frame loaded when a sequence becomes visible, so that the first
  // advance past the frame count lands on frame 0
  localparam logic [FRAME_W-1:0] ARM_FRAME = 8'd254;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_COUNT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_SETUP_BASE = 3'd1;

  // What one lane would do if the visit reached it
  typedef struct packed {
    logic               push;
    logic               changed;
    logic [FRAME_W-1:0] frame;
  } lane_req_t;

  // Outcome of the rotating pick
  typedef struct packed {
    logic                     pushed;
    logic [SEQ_W-1:0]         seq;
    logic [FRAME_W-1:0]       frame;
    logic                     changed;
    logic [MAX_SEQUENCES-1:0] commit;
    logic [SEQ_W-1:0]         next_ptr;
  } merge_t;

endpackage

// ===== hw/rtl/rrsas_lane.sv =====
// One sequence lane: setup, frame, cooldown and visibility state, and the
// request it would raise if visited this tick. Depends on rrsas_pkg.
module rrsas_lane (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           setup_wr,
  input  logic [rrsas_pkg::SETUP_W-1:0]  setup_data,
  input  logic                           mask_bit,
  input  logic                           commit,
  output rrsas_pkg::lane_req_t           req
);

  logic [rrsas_pkg::FRAME_W-1:0] length;
  logic [rrsas_pkg::SPEED_W-1:0] speed;
  logic [rrsas_pkg::FRAME_W-1:0] frame, frame_next;
  logic [rrsas_pkg::SPEED_W-1:0] cooldown, cooldown_next;
  logic                          drawn, drawn_next;
  logic                          seen, seen_next;

  logic [rrsas_pkg::SPEED_W-1:0] cd_dec;
  logic [rrsas_pkg::FRAME_W-1:0] frame_inc;

  // Next state if this lane is visited
  always_comb begin
    cd_dec        = cooldown - 1'b1;
    frame_inc     = frame + 1'b1;
    frame_next    = frame;
    cooldown_next = cooldown;
    drawn_next    = drawn;
    seen_next     = seen;
    req           = '0;
    if (!mask_bit) begin
      seen_next = 1'b0;
    end else if (!seen) begin
      // newly visible: arm, no draw
      frame_next    = rrsas_pkg::ARM_FRAME;
      drawn_next    = 1'b0;
      cooldown_next = 8'd1;
      seen_next     = 1'b1;
    end else if (drawn) begin
      // repeat for the second buffer
      drawn_next  = 1'b0;
      req.push    = 1'b1;
      req.changed = 1'b0;
      req.frame   = frame;
    end else begin
      cooldown_next = cd_dec;
      if (cd_dec == '0) begin
        cooldown_next = speed;
        frame_next    = (frame_inc >= length) ? '0 : frame_inc;
        drawn_next    = 1'b1;
        req.push      = 1'b1;
        req.changed   = 1'b1;
        req.frame     = frame_next;
      end
    end
  end

  // State registers; a setup write reinitialises the lane
  always_ff @(posedge clk) begin
    if (rst) begin
      length   <= '0;
      speed    <= '0;
      frame    <= '0;
      cooldown <= '0;
      drawn    <= 1'b0;
      seen     <= 1'b0;
    end else if (setup_wr) begin
      length   <= setup_data[rrsas_pkg::FRAME_W-1:0];
      speed    <= setup_data[rrsas_pkg::SETUP_W-1:rrsas_pkg::FRAME_W];
      frame    <= '0;
      cooldown <= setup_data[rrsas_pkg::SETUP_W-1:rrsas_pkg::FRAME_W];
      drawn    <= 1'b0;
      seen     <= 1'b0;
    end else if (commit) begin
      frame    <= frame_next;
      cooldown <= cooldown_next;
      drawn    <= drawn_next;
      seen     <= seen_next;
    end
  end

endmodule

// ===== hw/rtl/rrsas_merge.sv =====
// Rotating priority pick over the lane requests: finds the first pushing
// lane from the visit pointer, which lanes were visited, and the new pointer.
// Depends on rrsas_pkg.
module rrsas_merge (
  input  rrsas_pkg::lane_req_t            req [rrsas_pkg::MAX_SEQUENCES],
  input  logic [rrsas_pkg::CNT_W-1:0]     count,
  input  logic [rrsas_pkg::SEQ_W-1:0]     ptr,
  output rrsas_pkg::merge_t               res
);

  logic [rrsas_pkg::CNT_W-1:0] start_c;
  logic [rrsas_pkg::CNT_W-1:0] span [rrsas_pkg::MAX_SEQUENCES];
  logic [rrsas_pkg::CNT_W-1:0] s_c;
  logic [rrsas_pkg::CNT_W-1:0] best_d;
  logic [rrsas_pkg::CNT_W-1:0] nxt_c;
  logic [rrsas_pkg::SEQ_W-1:0] best_s;
  logic                        found;

  always_comb begin
    // a stale pointer past the active count restarts at lane 0
    start_c = (rrsas_pkg::CNT_W'(ptr) >= count) ? '0 : rrsas_pkg::CNT_W'(ptr);
    found   = 1'b0;
    best_d  = '0;
    best_s  = '0;
    res     = '0;

    // distance of each lane from the start, in visit order
    for (int s = 0; s < rrsas_pkg::MAX_SEQUENCES; s++) begin
      s_c     = rrsas_pkg::CNT_W'(s);
      span[s] = (s_c >= start_c) ? (s_c - start_c) : (s_c + count - start_c);
    end

    // nearest pushing lane wins
    for (int s = 0; s < rrsas_pkg::MAX_SEQUENCES; s++) begin
      s_c = rrsas_pkg::CNT_W'(s);
      if (s_c < count && req[s].push && (!found || span[s] < best_d)) begin
        found  = 1'b1;
        best_d = span[s];
        best_s = rrsas_pkg::SEQ_W'(s);
      end
    end

    // lanes up to and including the winner were visited (every active lane if none pushes)
    for (int s = 0; s < rrsas_pkg::MAX_SEQUENCES; s++) begin
      s_c           = rrsas_pkg::CNT_W'(s);
      res.commit[s] = (s_c < count) && (!found || span[s] <= best_d);
    end

    nxt_c = rrsas_pkg::CNT_W'(best_s) + 1'b1;
    if (count == '0) begin
      res.next_ptr = ptr;
    end else if (found) begin
      res.next_ptr = (nxt_c == count) ? '0 : rrsas_pkg::SEQ_W'(nxt_c);
    end else begin
      res.next_ptr = rrsas_pkg::SEQ_W'(start_c);
    end

    res.pushed = found;
    if (found) begin
      res.seq     = best_s;
      res.frame   = req[best_s].frame;
      res.changed = req[best_s].changed;
    end
  end

endmodule

// ===== hw/rtl/round_robin_sprite_animation_scheduler_core.sv =====
// Round-robin sprite animation scheduler, top level.
// Instantiates one rrsas_lane per sequence and rrsas_merge; uses rrsas_pkg.
//
// Usage
//   Configuration: cfg_we/cfg_index/cfg_data write one register per cycle.
//   Index 0 sets the number of active sequences (saturated at the lane
//   count) and returns the visit pointer to lane 0. Index 1+n loads the
//   frame count (low byte) and ticks per frame (high byte) of sequence n
//   and reinitialises that sequence. Write only while the block is idle.
//   Tick channel: tick_valid/tick_ready carry visible_mask, one transaction
//   per display frame.
//   Result channel: result_valid/result_ready carry pushed, pushed_sequence,
//   frame_index and frame_changed; exactly one result per tick.
// Timing
//   Every lane evaluates its sequence in parallel and the rotating pick
//   settles the visit in the same cycle, so a result appears in the cycle
//   after its tick is accepted; unstalled, one tick is taken every cycle.
//   The single output register decides the rate under back-pressure: while
//   a result waits on a stalled receiver, tick_ready stays low; the next
//   tick is taken in the cycle the waiting result is taken.
// Reset
//   rst (synchronous) clears all setup, lane state, the pointer and the
//   output valid flag; no sequences are active afterwards.
module round_robin_sprite_animation_scheduler_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rrsas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrsas_pkg::SETUP_W-1:0]      cfg_data,
  input  logic                               tick_valid,
  output logic                               tick_ready,
  input  logic [rrsas_pkg::MASK_W-1:0]       visible_mask,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic                               pushed,
  output logic [rrsas_pkg::SEQ_OUT_W-1:0]    pushed_sequence,
  output logic [rrsas_pkg::FRAME_W-1:0]      frame_index,
  output logic                               frame_changed
);

  localparam int PAD_W = rrsas_pkg::MAX_SEQUENCES + rrsas_pkg::MASK_W;

  logic [rrsas_pkg::CNT_W-1:0] count;
  logic [rrsas_pkg::SEQ_W-1:0] ptr;
  logic                        accept;
  logic [PAD_W-1:0]            mask_pad;
  rrsas_pkg::lane_req_t        req [rrsas_pkg::MAX_SEQUENCES];
  rrsas_pkg::merge_t           res;

  assign tick_ready = !result_valid || result_ready;
  assign accept     = tick_valid && tick_ready;
  assign mask_pad   = PAD_W'(visible_mask);

  // Sequence lanes
  for (genvar s = 0; s < rrsas_pkg::MAX_SEQUENCES; s++) begin : g_lane
    logic setup_wr;
    assign setup_wr = cfg_we && (s < rrsas_pkg::SETUP_REGS) &&
                      (cfg_index == rrsas_pkg::CFG_SEQ_SETUP_BASE +
                                    rrsas_pkg::CFG_IDX_W'(s));
    rrsas_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .setup_wr   (setup_wr),
      .setup_data (cfg_data),
      .mask_bit   (mask_pad[s]),
      .commit     (accept && res.commit[s]),
      .req        (req[s])
    );
  end

  // Rotating pick
  rrsas_merge u_merge (
    .req   (req),
    .count (count),
    .ptr   (ptr),
    .res   (res)
  );

  // Active count and visit pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
    end else if (cfg_we && cfg_index == rrsas_pkg::CFG_SEQ_COUNT) begin
      if (int'(cfg_data[rrsas_pkg::COUNT_FIELD_W-1:0]) > rrsas_pkg::MAX_SEQUENCES) begin
        count <= rrsas_pkg::CNT_W'(rrsas_pkg::MAX_SEQUENCES);
      end else begin
        count <= rrsas_pkg::CNT_W'(cfg_data[rrsas_pkg::COUNT_FIELD_W-1:0]);
      end
      ptr <= '0;
    end else if (accept) begin
      ptr <= res.next_ptr;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pushed          <= res.pushed;
      pushed_sequence <= rrsas_pkg::SEQ_OUT_W'(res.seq);
      frame_index     <= res.frame;
      frame_changed   <= res.changed;
    end
  end

endmodule

// ===== hw/rtl/rrsas_checker.sv =====
// Port-level checks for the scheduler top level, with the bind that
// attaches them. Depends on rrsas_pkg and the top level's ports.
module rrsas_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            tick_valid,
  input logic                            tick_ready,
  input logic                            result_valid,
  input logic                            result_ready,
  input logic                            pushed,
  input logic [rrsas_pkg::SEQ_OUT_W-1:0] pushed_sequence,
  input logic [rrsas_pkg::FRAME_W-1:0]   frame_index,
  input logic                            frame_changed
);

  // Result register is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A result without a push carries zero fields
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !pushed |->
      pushed_sequence == '0 && frame_index == '0 && !frame_changed)
    else $error("non-zero fields on a result without a push");

  // Pushed sequence names an existing lane
  a_seq_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && pushed |->
      int'(pushed_sequence) < rrsas_pkg::MAX_SEQUENCES)
    else $error("pushed sequence out of range");

  // An accepted tick shows its result in the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> result_valid)
    else $error("no result after an accepted tick");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(pushed) &&
      $stable(pushed_sequence) && $stable(frame_index) && $stable(frame_changed))
    else $error("stalled result changed");

endmodule

bind round_robin_sprite_animation_scheduler_core rrsas_checker u_rrsas_checker (
  .clk             (clk),
  .rst             (rst),
  .tick_valid      (tick_valid),
  .tick_ready      (tick_ready),
  .result_valid    (result_valid),
  .result_ready    (result_ready),
  .pushed          (pushed),
  .pushed_sequence (pushed_sequence),
  .frame_index     (frame_index),
  .frame_changed   (frame_changed)
);
